// ===== design/ppj_pkg.sv =====
// Shared types, widths and the division step helper function for the starfield point projector.
// No dependencies; every other design file imports this package.
package ppj_pkg;

  localparam int unsigned CoordW     = 12;
  localparam int unsigned ZW         = 10;
  localparam int unsigned FtW        = 9;
  localparam int unsigned ScaleW     = 16;
  localparam int unsigned ResW       = 11;
  localparam int unsigned AddrW      = 20;
  localparam int unsigned BrightW    = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // Depth wraps modulo 512.
  localparam int unsigned DepthW     = 9;

  // Products and numerator of the projection.
  localparam int unsigned ProdW      = CoordW + ScaleW + 1;
  localparam int unsigned HalfW      = (ResW - 1) + DepthW;
  localparam int unsigned NumW       = 30;
  localparam int unsigned MagW       = 28;

  // Divider: magnitude over 256 divided by the depth.
  localparam int unsigned QuotW      = MagW - 8;
  localparam int unsigned RemW       = DepthW;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages  = QuotW / StepsPerStage;

  localparam int unsigned MulW       = 2 * ResW;

  localparam logic [FtW-1:0]    FtReset    = FtW'(0);
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(256);
  localparam logic [ResW-1:0]   XResReset  = ResW'(320);
  localparam logic [ResW-1:0]   YResReset  = ResW'(180);
  localparam logic [6:0]        FullBright = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_TIME  = 2'd0,
    CFG_PERSP_SCALE = 2'd1,
    CFG_X_RES       = 2'd2,
    CFG_Y_RES       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FtW-1:0]    frame_time;
    logic [ScaleW-1:0] persp_scale;
    logic [ResW-1:0]   x_res;
    logic [ResW-1:0]   y_res;
  } ppj_cfg_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] word;
  } ppj_lane_t;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              neg_x;
    logic              neg_y;
    ppj_lane_t         lane_x;
    ppj_lane_t         lane_y;
  } ppj_div_t;

  // One restoring division step: the dividend bits leave the top of word
  // while the quotient bits enter at the bottom.
  function automatic ppj_lane_t ppj_div_step(ppj_lane_t l, logic [DepthW-1:0] d);
    logic [RemW:0] t;
    ppj_lane_t     o;
    t = {l.rem, l.word[QuotW-1]};
    if (t >= {1'b0, d}) begin
      o.rem  = RemW'(t - {1'b0, d});
      o.word = {l.word[QuotW-2:0], 1'b1};
    end else begin
      o.rem  = t[RemW-1:0];
      o.word = {l.word[QuotW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== design/star_if.sv =====
// Input channel carrying one star per item.
// Depends on ppj_pkg for field widths.
interface star_if;
  import ppj_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] star_x;
  logic signed [CoordW-1:0] star_y;
  logic [ZW-1:0]            star_z;

  modport source (output valid, star_x, star_y, star_z, input ready);
  modport sink (input valid, star_x, star_y, star_z, output ready);
endinterface

// ===== design/pixel_if.sv =====
// Output channel carrying one framebuffer write request per item.
// Depends on ppj_pkg for field widths.
interface pixel_if;
  import ppj_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_pixel;
  logic [AddrW-1:0]   pixel_address;
  logic [BrightW-1:0] brightness;

  modport source (output valid, write_pixel, pixel_address, brightness, input ready);
  modport sink (input valid, write_pixel, pixel_address, brightness, output ready);
endinterface

// ===== design/ppj_front.sv =====
// Front of the projector pipeline: depth, products and numerator magnitude.
// Depends on ppj_pkg; feeds ppj_div.
module ppj_front (
  input  logic              clk,
  input  logic              rst,
  input  ppj_pkg::ppj_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [ppj_pkg::CoordW-1:0] star_x,
  input  logic signed [ppj_pkg::CoordW-1:0] star_y,
  input  logic [ppj_pkg::ZW-1:0]            star_z,
  output logic              out_valid,
  input  logic              out_ready,
  output ppj_pkg::ppj_div_t out_data
);
  import ppj_pkg::*;

  logic                    valid_a;
  logic                    valid_b;
  logic                    ready_a;
  logic                    ready_b;
  logic [DepthW-1:0]       depth_a;
  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  logic [HalfW-1:0]        half_x;
  logic [HalfW-1:0]        half_y;
  logic [DepthW-1:0]       depth_next;
  logic signed [NumW-1:0]  num_x;
  logic signed [NumW-1:0]  num_y;
  logic [NumW-1:0]         mag_x;
  logic [NumW-1:0]         mag_y;
  ppj_div_t                data_b;
  ppj_div_t                data_b_next;

  assign ready_b   = !valid_b || out_ready;
  assign ready_a   = !valid_a || ready_b;
  assign in_ready  = ready_a;
  assign out_valid = valid_b;
  assign out_data  = data_b;

  // Depth is the low bits of the difference, so the wrap is free.
  assign depth_next = star_z[DepthW-1:0] - cfg.frame_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a <= in_valid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      depth_a <= depth_next;
      prod_x  <= star_x * $signed({1'b0, cfg.persp_scale});
      prod_y  <= star_y * $signed({1'b0, cfg.persp_scale});
      half_x  <= HalfW'(cfg.x_res[ResW-1:1]) * HalfW'(depth_next);
      half_y  <= HalfW'(cfg.y_res[ResW-1:1]) * HalfW'(depth_next);
    end
    if (ready_b && valid_a) begin
      data_b <= data_b_next;
    end
  end

  always_comb begin
    num_x = $signed({3'b000, half_x, 8'h00}) + $signed({prod_x[ProdW-1], prod_x});
    num_y = $signed({3'b000, half_y, 8'h00}) + $signed({prod_y[ProdW-1], prod_y});
    mag_x = num_x[NumW-1] ? NumW'(-num_x) : NumW'(num_x);
    mag_y = num_y[NumW-1] ? NumW'(-num_y) : NumW'(num_y);
    data_b_next.depth       = depth_a;
    data_b_next.neg_x       = num_x[NumW-1];
    data_b_next.neg_y       = num_y[NumW-1];
    // Dividing by 256*d is the same as dropping eight bits and dividing by d.
    data_b_next.lane_x.rem  = '0;
    data_b_next.lane_x.word = mag_x[MagW-1:8];
    data_b_next.lane_y.rem  = '0;
    data_b_next.lane_y.word = mag_y[MagW-1:8];
  end

endmodule

// ===== design/ppj_div.sv =====
// Pipelined restoring divider for both axes, a few quotient bits per stage.
// Depends on ppj_pkg for the lane types and the step function.
module ppj_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppj_pkg::ppj_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppj_pkg::ppj_div_t out_data
);
  import ppj_pkg::*;

  logic     valid [DivStages];
  logic     rdy [DivStages];
  logic     prev_valid [DivStages];
  ppj_div_t data [DivStages];
  ppj_div_t stage_out [DivStages];

  assign in_ready  = rdy[0];
  assign out_valid = valid[DivStages-1];
  assign out_data  = data[DivStages-1];

  always_comb begin
    ppj_div_t tmp;
    for (int s = 0; s < DivStages; s++) begin
      tmp = (s == 0) ? in_data : data[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < StepsPerStage; k++) begin
        tmp.lane_x = ppj_div_step(tmp.lane_x, tmp.depth);
        tmp.lane_y = ppj_div_step(tmp.lane_y, tmp.depth);
      end
      stage_out[s] = tmp;
    end
  end

  always_comb begin
    rdy[DivStages-1] = !valid[DivStages-1] || out_ready;
    for (int s = DivStages - 2; s >= 0; s--) begin
      rdy[s] = !valid[s] || rdy[s+1];
    end
    prev_valid[0] = in_valid;
    for (int s = 1; s < DivStages; s++) begin
      prev_valid[s] = valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DivStages; s++) begin
        valid[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < DivStages; s++) begin
        if (rdy[s]) begin
          valid[s] <= prev_valid[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DivStages; s++) begin
      if (rdy[s] && prev_valid[s]) begin
        data[s] <= stage_out[s];
      end
    end
  end

endmodule

// ===== design/ppj_back.sv =====
// Back of the projector pipeline: screen test, address and brightness.
// Depends on ppj_pkg; takes quotients from ppj_div, drives the output channel.
module ppj_back (
  input  logic              clk,
  input  logic              rst,
  input  ppj_pkg::ppj_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppj_pkg::ppj_div_t in_data,
  pixel_if.source           pixel
);
  import ppj_pkg::*;

  logic               valid_c;
  logic               valid_d;
  logic               ready_c;
  logic               ready_d;
  logic               write_c;
  logic [MulW-1:0]    row_c;
  logic [ResW-1:0]    col_c;
  logic [BrightW-1:0] bright_c;
  logic               on_x;
  logic               on_y;
  logic [6:0]         up;
  logic               write_d;
  logic [AddrW-1:0]   addr_d;
  logic [BrightW-1:0] bright_d;

  assign ready_d  = !valid_d || pixel.ready;
  assign ready_c  = !valid_c || ready_d;
  assign in_ready = ready_c;

  assign pixel.valid         = valid_d;
  assign pixel.write_pixel   = write_d;
  assign pixel.pixel_address = addr_d;
  assign pixel.brightness    = bright_d;

  // A negative quotient is off screen unless it truncated to zero.
  assign on_x = (!in_data.neg_x || (in_data.lane_x.word == '0))
             && (in_data.lane_x.word < QuotW'(cfg.x_res));
  assign on_y = (!in_data.neg_y || (in_data.lane_y.word == '0))
             && (in_data.lane_y.word < QuotW'(cfg.y_res));
  assign up   = 7'(({1'b0, in_data.depth} + 10'd7) >> 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c <= in_valid;
      end
      if (ready_d) begin
        valid_d <= valid_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && in_valid) begin
      write_c  <= (in_data.depth != '0) && on_x && on_y;
      row_c    <= in_data.lane_y.word[ResW-1:0] * cfg.x_res;
      col_c    <= in_data.lane_x.word[ResW-1:0];
      bright_c <= BrightW'(FullBright - up);
    end
    if (ready_d && valid_c) begin
      write_d  <= write_c;
      addr_d   <= write_c ? AddrW'(row_c + MulW'(col_c)) : '0;
      bright_d <= write_c ? bright_c : '0;
    end
  end

endmodule

// ===== design/starfield_point_projector.sv =====
// Top level of the starfield point projector: configuration registers and
// the pipeline. Depends on ppj_pkg, star_if, pixel_if, ppj_front, ppj_div, ppj_back.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------
//   star     | in        | star_x, star_y, star_z
//   pixel    | out       | write_pixel, pixel_address, brightness
//   cfg      | in        | cfg_write, cfg_index, cfg_data (write only)
//
// One item enters per cycle unless the output stalls; it passes through two front
// stages, five divider stages of four quotient bits each, and two back stages.
// Every stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stall on the output fills bubbles before it stops input.
// Reset clears the valid bits and loads the register defaults.
module starfield_point_projector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ppj_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppj_pkg::CfgDataW-1:0]  cfg_data,
  star_if.sink                          star,
  pixel_if.source                       pixel
);
  import ppj_pkg::*;

  ppj_cfg_t cfg;
  logic     front_valid;
  logic     front_ready;
  ppj_div_t front_data;
  logic     div_valid;
  logic     div_ready;
  ppj_div_t div_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_time  <= FtReset;
      cfg.persp_scale <= ScaleReset;
      cfg.x_res       <= XResReset;
      cfg.y_res       <= YResReset;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_TIME:  cfg.frame_time  <= cfg_data[FtW-1:0];
        CFG_PERSP_SCALE: cfg.persp_scale <= cfg_data[ScaleW-1:0];
        CFG_X_RES:       cfg.x_res       <= cfg_data[ResW-1:0];
        CFG_Y_RES:       cfg.y_res       <= cfg_data[ResW-1:0];
      endcase
    end
  end

  ppj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (star.valid),
    .in_ready  (star.ready),
    .star_x    (star.star_x),
    .star_y    (star.star_y),
    .star_z    (star.star_z),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  ppj_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  ppj_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .in_data  (div_data),
    .pixel    (pixel)
  );

endmodule

// ===== sim/tb_starfield_point_projector.sv =====
// Self-checking testbench for the starfield point projector.
// Depends on ppj_pkg, star_if, pixel_if and the design files. Stars are projected by an
// in-bench predictor and every pixel item is checked against it in order.
module tb_starfield_point_projector;
  import ppj_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [ZW-1:0]            z;
  } star_t;

  typedef struct packed {
    logic               wr;
    logic [AddrW-1:0]   addr;
    logic [BrightW-1:0] bright;
  } pix_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  star_if  star_ch();
  pixel_if pixel_ch();

  starfield_point_projector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .star      (star_ch),
    .pixel     (pixel_ch)
  );

  // Predictor copy of the configuration registers.
  logic [FtW-1:0]    frame_time_q;
  logic [ScaleW-1:0] persp_scale_q;
  logic [ResW-1:0]   x_res_q;
  logic [ResW-1:0]   y_res_q;

  star_t stars_to_send[$];
  pix_t  expected_pixels[$];

  bit    idle_en;
  logic  star_fire;
  int    send_gap;
  int    stall_left;
  int    cycles;
  int    errors;
  int    stars_accepted;
  int    results_checked;
  int    writes_seen;
  int    reg_writes;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Perspective projection of one star under the current register values.
  // The sum is formed exactly and only then truncated toward zero.
  function automatic pix_t project_star(star_t s);
    logic [DepthW-1:0] depth;
    longint den, px, py;
    int up;
    pix_t r;
    r = '0;
    depth = s.z[DepthW-1:0] - frame_time_q;
    if (depth != 0) begin
      den = 256 * longint'(depth);
      px = (longint'(x_res_q >> 1) * den + longint'($signed(s.x)) * longint'(persp_scale_q)) / den;
      py = (longint'(y_res_q >> 1) * den + longint'($signed(s.y)) * longint'(persp_scale_q)) / den;
      if (px >= 0 && py >= 0 && px < longint'(x_res_q) && py < longint'(y_res_q)) begin
        up = (int'(depth) + 7) >> 3;
        r.wr = 1'b1;
        r.addr = AddrW'(py * longint'(x_res_q) + px);
        r.bright = BrightW'(64 - up);
      end
    end
    return r;
  endfunction

  function automatic void add_star(int x, int y, int z);
    star_t s;
    s.x = CoordW'(x);
    s.y = CoordW'(y);
    s.z = ZW'(z);
    stars_to_send.push_back(s);
  endfunction

  // A quarter of the stars have fully random fields; the rest have coordinates
  // of random magnitude so that many of them land on screen.
  function automatic star_t random_star();
    star_t s;
    int k;
    if ($urandom_range(0, 3) == 0) begin
      s.x = CoordW'($urandom);
      s.y = CoordW'($urandom);
    end else begin
      k = $urandom_range(0, 11);
      s.x = CoordW'($urandom_range(0, (1 << k) - 1));
      if ($urandom_range(0, 1) == 1) s.x = -s.x;
      k = $urandom_range(0, 11);
      s.y = CoordW'($urandom_range(0, (1 << k) - 1));
      if ($urandom_range(0, 1) == 1) s.y = -s.y;
    end
    s.z = ZW'($urandom);
    return s;
  endfunction

  function automatic void add_random_stars(int n);
    for (int i = 0; i < n; i++) stars_to_send.push_back(random_star());
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] ft, logic [15:0] scale, logic [15:0] xr,
                            logic [15:0] yr);
    write_reg(CFG_FRAME_TIME, ft);
    write_reg(CFG_PERSP_SCALE, scale);
    write_reg(CFG_X_RES, xr);
    write_reg(CFG_Y_RES, yr);
  endtask

  // Returns once every queued star has been sent and every pixel item has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (stars_to_send.size() != 0 || star_ch.valid || expected_pixels.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [15:0] random_res();
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return 16'd1024;
      default: return 16'($urandom_range(1, 1024));
    endcase
  endfunction

  always @(negedge clk) begin : drive_stars
    logic  send;
    star_t nxt;
    if (rst) begin
      star_ch.valid <= 1'b0;
    end else if (!star_ch.valid || star_fire) begin
      send = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (stars_to_send.size() > 0) begin
        if (idle_en && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 6);
        end else begin
          nxt = stars_to_send.pop_front();
          send = 1'b1;
          star_ch.star_x <= nxt.x;
          star_ch.star_y <= nxt.y;
          star_ch.star_z <= nxt.z;
        end
      end
      star_ch.valid <= send;
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      pixel_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pixel_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    pix_t want;
    if (rst) begin
      star_fire     <= 1'b0;
      frame_time_q  <= FtReset;
      persp_scale_q <= ScaleReset;
      x_res_q       <= XResReset;
      y_res_q       <= YResReset;
    end else begin
      star_fire <= star_ch.valid && star_ch.ready;
      if (star_ch.valid && star_ch.ready) begin
        expected_pixels.push_back(project_star({star_ch.star_x, star_ch.star_y,
                                                star_ch.star_z}));
        stars_accepted++;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel item: wr=%0d addr=%0d bright=%0d", $time,
                   pixel_ch.write_pixel, pixel_ch.pixel_address, pixel_ch.brightness);
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (want.wr) writes_seen++;
          if (pixel_ch.write_pixel !== want.wr || pixel_ch.pixel_address !== want.addr ||
              pixel_ch.brightness !== want.bright) begin
            errors++;
            $display("%0t: mismatch: expected wr=%0d addr=%0d bright=%0d, got wr=%0d addr=%0d bright=%0d",
                     $time, want.wr, want.addr, want.bright, pixel_ch.write_pixel,
                     pixel_ch.pixel_address, pixel_ch.brightness);
          end
        end
      end
      // A register write takes effect after this edge, so the star above
      // still saw the old value.
      if (cfg_write) begin
        reg_writes++;
        case (cfg_index)
          CFG_FRAME_TIME:  frame_time_q  <= cfg_data[FtW-1:0];
          CFG_PERSP_SCALE: persp_scale_q <= cfg_data[ScaleW-1:0];
          CFG_X_RES:       x_res_q       <= cfg_data[ResW-1:0];
          CFG_Y_RES:       y_res_q       <= cfg_data[ResW-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run stopped at the cycle limit with %0d items outstanding", $time,
               expected_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_FRAME_TIME;
    cfg_data       = '0;
    star_ch.valid  = 1'b0;
    star_ch.star_x = '0;
    star_ch.star_y = '0;
    star_ch.star_z = '0;
    pixel_ch.ready = 1'b0;
    idle_en        = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset values: 320 by 180, unit scale, frame time zero.
    add_star(0, 0, 0);           // depth zero
    add_star(5, 5, 512);         // depth wraps to zero
    add_star(0, 0, 1);           // nearest star, full brightness
    add_star(0, 0, 511);         // farthest star
    add_star(3, -3, 1023);
    add_star(-2048, -2048, 1);   // far off screen, negative side
    add_star(2047, 2047, 1);     // far off screen, positive side
    add_star(-160, -90, 1);      // top-left pixel
    add_star(159, 89, 1);        // bottom-right pixel
    add_star(-161, 0, 1);        // one pixel left of the screen
    add_star(160, 0, 1);         // one pixel right of the screen
    add_star(0, -91, 1);
    add_star(0, 90, 1);
    add_star(-321, -181, 2);     // sum of -0.5 truncates to zero, on screen
    add_star(-1, -1, 1023);
    add_star(1365, -1366, 682);
    add_star(-1024, 1024, 9);
    wait_idle();

    // Extremes: largest scale, resolution 1024, latest frame time. No idling here.
    idle_en = 1'b0;
    set_config(16'd511, 16'hFFFF, 16'd1024, 16'd1024);
    add_star(0, 0, 511);         // depth zero after the time offset
    add_star(0, 0, 1023);        // wraps to depth zero
    add_star(1, 1, 0);
    add_star(-2, 2, 510);
    add_random_stars(60);
    wait_idle();

    // Zero scale and a single pixel: every visible star lands on address 0.
    idle_en = 1'b1;
    set_config(16'd0, 16'd0, 16'd1, 16'd1);
    add_random_stars(40);
    wait_idle();

    // Upper bits are dropped: resolution 2047, addresses wrap at 20 bits.
    set_config(16'hFFFF, 16'd256, 16'hFFFF, 16'hFFFF);
    add_star(0, 0, 12);
    add_star(1000, 1000, 1);
    add_random_stars(60);
    wait_idle();

    // Zero width, then zero height: nothing can be written.
    set_config(16'd17, 16'd300, 16'd0, 16'd200);
    add_random_stars(20);
    wait_idle();
    set_config(16'd17, 16'd300, 16'd1024, 16'd0);
    add_random_stars(20);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0: set_config(16'($urandom_range(0, 511)), 16'($urandom), random_res(), random_res());
        1: set_config(16'($urandom_range(0, 511)), 16'($urandom_range(0, 1023)),
                      random_res(), random_res());
        default: set_config(16'($urandom_range(0, 511)), 16'd256, random_res(), random_res());
      endcase
      add_random_stars(60);
      wait_idle();
    end

    // Final stretch at full rate on both sides.
    idle_en = 1'b0;
    set_config(16'($urandom_range(0, 511)), 16'd512, 16'd640, 16'd480);
    add_random_stars(80);
    wait_idle();
    repeat (20) @(negedge clk);

    if (expected_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixel items never arrived", $time, expected_pixels.size());
    end
    $display("Projected %0d stars over %0d register writes; %0d pixel items checked.",
             stars_accepted, reg_writes, results_checked);
    $display("%0d of them were framebuffer writes, the rest hidden or off screen.",
             writes_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
